[src/rational_accumulator_unit_core_defines.svh]
// Assertion macros shared by the rational accumulator RTL
`ifndef RATIONAL_ACCUMULATOR_UNIT_CORE_DEFINES_SVH
`define RATIONAL_ACCUMULATOR_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, reset masked
`define RAU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masked
`define RAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rau_pkg.sv]
// Shared types and constants for the rational accumulator
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;

    localparam int WIDTH_DEF = 32;
    localparam int FIELD_W   = 32;
    localparam int DEN_OUT_W = 31;
    localparam int IN_DATA_W = 72;
    localparam int OUT_DATA_W = 72;

    typedef enum logic [2:0] {
        REQ_LOAD = 3'd0,
        REQ_ADD  = 3'd1,
        REQ_SUB  = 3'd2,
        REQ_MUL  = 3'd3,
        REQ_DIV  = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_OVF  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_COMBINE,
        S_GCD,
        S_DIVIDE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic       load_in;
        logic       mul_en;
        logic [1:0] mul_idx;
        logic       combine;
        logic       gcd_step;
        logic       div_init;
        logic       div_step;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic err;
        logic ign;
        logic is_load;
        logic nm_zero;
        logic gcd_done;
        logic div_done;
    } sts_t;

endpackage
`default_nettype wire

[src/rau_ctrl.sv]
// Sequencing state machine for the rational accumulator
`timescale 1ns / 1ps
`default_nettype none
`include "rational_accumulator_unit_core_defines.svh"
module rau_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire rau_pkg::sts_t sts,
    output rau_pkg::cmd_t      cmd
);
    import rau_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (s_tvalid) state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                if (sts.err || sts.ign) state_next = S_FINISH;
                else if (sts.is_load)   state_next = S_COMBINE;
                else                    state_next = S_MUL0;
            end
            S_MUL0:     state_next = S_MUL1;
            S_MUL1:     state_next = S_MUL2;
            S_MUL2:     state_next = S_COMBINE;
            S_COMBINE:  state_next = S_GCD;
            S_GCD:
            begin
                if (sts.nm_zero)       state_next = S_FINISH;
                else if (sts.gcd_done) state_next = S_DIVIDE;
            end
            S_DIVIDE:   if (sts.div_done) state_next = S_FINISH;
            S_FINISH:   if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE:    cmd.load_in = s_tvalid;
            S_MUL0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_idx = 2'd0;
            end
            S_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_idx = 2'd1;
            end
            S_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_idx = 2'd2;
            end
            S_COMBINE: cmd.combine = 1'b1;
            S_GCD:
            begin
                cmd.gcd_step = !sts.nm_zero && !sts.gcd_done;
                cmd.div_init = !sts.nm_zero && sts.gcd_done;
            end
            S_DIVIDE:  cmd.div_step = 1'b1;
            S_FINISH:
            begin
                cmd.finish = out_free;
                if (out_free) m_tvalid_next = 1'b1;
            end
            default:   cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `RAU_ASSERT_NEXT(a_finish_publish, (state_reg == S_FINISH) && out_free, (state_reg == S_IDLE) && m_tvalid_reg, "finished beat not published")
    `RAU_ASSERT_NEXT(a_finish_hold, (state_reg == S_FINISH) && !out_free, state_reg == S_FINISH, "finish left while output busy")
    `RAU_ASSERT_NOW(a_div_init_once, cmd.div_init, !cmd.gcd_step && (state_reg == S_GCD), "divider init outside gcd end")

endmodule
`default_nettype wire

[src/rau_dp.sv]
// Datapath: multiplier, sign combine, binary GCD and restoring divider
`timescale 1ns / 1ps
`default_nettype none
`include "rational_accumulator_unit_core_defines.svh"
module rau_dp #(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [2:0]                    req_type,
    input  wire logic [rau_pkg::FIELD_W-1:0]   operand_num,
    input  wire logic [rau_pkg::FIELD_W-1:0]   operand_den,
    input  wire rau_pkg::cmd_t                 cmd,
    output rau_pkg::sts_t                      sts,
    output logic [rau_pkg::FIELD_W-1:0]        result_num,
    output logic [rau_pkg::DEN_OUT_W-1:0]      result_den,
    output logic [1:0]                         status
);
    import rau_pkg::*;

    localparam logic [63:0] HALF = 64'(1) << (WIDTH - 1);

    logic signed [WIDTH-1:0] acc_num_reg;
    logic [WIDTH-2:0]        acc_den_reg;

    logic [2:0]  req_reg;
    logic [31:0] on_reg, od_reg;
    logic        on_neg_reg, od_neg_reg;
    logic [63:0] prod_a_reg, prod_b_reg, prod_d_reg;
    logic [63:0] nm_reg, dm_reg;
    logic        ns_reg;
    logic [63:0] u_reg, v_reg, g_reg, dvd_reg, rem_reg;
    logic [5:0]  k_reg, cnt_reg;
    logic        div_sel_reg;
    logic [31:0] out_num_reg;
    logic [30:0] out_den_reg;
    status_t     out_status_reg;

    logic [31:0] an, ad, mul_x, mul_y;
    logic        an_neg, os;
    logic [31:0] acc_ext;
    logic [63:0] mul_p;
    logic [63:0] nm_c, dm_c;
    logic        ns_c;
    logic [64:0] rem_sh, rem_diff;
    logic        q_bit;
    logic [63:0] q_next;
    logic        err_c, ign_c, fits;
    logic [63:0] num_raw;

    function automatic logic [31:0] mag(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [64:0] sm_add(input logic sa, input logic [63:0] ma,
                                           input logic sb, input logic [63:0] mb);
        logic [64:0] r;
        if (sa == sb)      r = {sa, ma + mb};
        else if (ma >= mb) r = {sa, ma - mb};
        else               r = {sb, mb - ma};
        return r;
    endfunction

    assign acc_ext = 32'(acc_num_reg);
    assign an_neg  = acc_ext[31];
    assign an      = mag(acc_ext);
    assign ad      = 32'(acc_den_reg);
    assign os      = on_neg_reg ^ od_neg_reg;

    assign ign_c = (req_reg > REQ_DIV);
    assign err_c = !ign_c &&
                   ((od_reg == 32'd0) || ((req_reg == REQ_DIV) && (on_reg == 32'd0)));

    always_comb
    begin
        case (cmd.mul_idx)
            2'd0:
            begin
                mul_x = an;
                mul_y = (req_reg == REQ_MUL) ? on_reg : od_reg;
            end
            2'd1:
            begin
                mul_x = ad;
                mul_y = on_reg;
            end
            default:
            begin
                mul_x = ad;
                mul_y = od_reg;
            end
        endcase
    end
    assign mul_p = 64'(mul_x) * 64'(mul_y);

    always_comb
    begin
        logic [64:0] s;
        s    = '0;
        nm_c = 64'(on_reg);
        dm_c = 64'(od_reg);
        ns_c = os;
        unique case (req_reg)
            REQ_LOAD: ;
            REQ_ADD:
            begin
                s    = sm_add(an_neg, prod_a_reg, os, prod_b_reg);
                nm_c = s[63:0];
                ns_c = s[64];
                dm_c = prod_d_reg;
            end
            REQ_SUB:
            begin
                s    = sm_add(an_neg, prod_a_reg, !os, prod_b_reg);
                nm_c = s[63:0];
                ns_c = s[64];
                dm_c = prod_d_reg;
            end
            REQ_MUL:
            begin
                nm_c = prod_a_reg;
                dm_c = prod_d_reg;
                ns_c = an_neg ^ os;
            end
            REQ_DIV:
            begin
                nm_c = prod_a_reg;
                dm_c = prod_b_reg;
                ns_c = an_neg ^ os;
            end
            default: ;
        endcase
        if (nm_c == 64'd0)
        begin
            dm_c = 64'd1;
            ns_c = 1'b0;
        end
    end

    assign rem_sh   = {rem_reg, dvd_reg[63]};
    assign rem_diff = rem_sh - {1'b0, g_reg};
    assign q_bit    = !rem_diff[64];
    assign q_next   = {dvd_reg[62:0], q_bit};

    assign fits    = (ns_reg ? (nm_reg <= HALF) : (nm_reg < HALF)) && (dm_reg < HALF);
    assign num_raw = ns_reg ? (64'd0 - nm_reg) : nm_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_reg    <= req_type;
            on_reg     <= mag(operand_num);
            od_reg     <= mag(operand_den);
            on_neg_reg <= operand_num[31];
            od_neg_reg <= operand_den[31];
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_idx)
                2'd0:    prod_a_reg <= mul_p;
                2'd1:    prod_b_reg <= mul_p;
                default: prod_d_reg <= mul_p;
            endcase
        end
        if (cmd.combine)
        begin
            nm_reg <= nm_c;
            dm_reg <= dm_c;
            ns_reg <= ns_c;
            u_reg  <= nm_c;
            v_reg  <= dm_c;
            k_reg  <= '0;
        end
        if (cmd.gcd_step)
        begin
            if (!u_reg[0] && !v_reg[0])
            begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + 6'd1;
            end
            else if (!u_reg[0]) u_reg <= u_reg >> 1;
            else if (!v_reg[0]) v_reg <= v_reg >> 1;
            else if (u_reg > v_reg) u_reg <= u_reg - v_reg;
            else v_reg <= v_reg - u_reg;
        end
        if (cmd.div_init)
        begin
            g_reg       <= u_reg << k_reg;
            dvd_reg     <= nm_reg;
            rem_reg     <= '0;
            cnt_reg     <= '0;
            div_sel_reg <= 1'b0;
        end
        if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'h3f)
            begin
                rem_reg <= '0;
                if (!div_sel_reg)
                begin
                    nm_reg      <= q_next;
                    dvd_reg     <= dm_reg;
                    div_sel_reg <= 1'b1;
                end
                else
                begin
                    dm_reg  <= q_next;
                    dvd_reg <= q_next;
                end
            end
            else
            begin
                rem_reg <= q_bit ? rem_diff[63:0] : rem_sh[63:0];
                dvd_reg <= q_next;
            end
        end
        if (cmd.finish)
        begin
            if (err_c)
            begin
                out_status_reg <= ST_ZERO;
                out_num_reg    <= acc_ext;
                out_den_reg    <= 31'(acc_den_reg);
            end
            else if (ign_c)
            begin
                out_status_reg <= ST_OK;
                out_num_reg    <= acc_ext;
                out_den_reg    <= 31'(acc_den_reg);
            end
            else if (!fits)
            begin
                out_status_reg <= ST_OVF;
                out_num_reg    <= acc_ext;
                out_den_reg    <= 31'(acc_den_reg);
            end
            else
            begin
                out_status_reg <= ST_OK;
                out_num_reg    <= 32'(signed'(num_raw[WIDTH-1:0]));
                out_den_reg    <= 31'(dm_reg[WIDTH-2:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_num_reg <= '0;
            acc_den_reg <= (WIDTH-1)'(1);
        end
        else if (cmd.finish && !err_c && !ign_c && fits)
        begin
            acc_num_reg <= signed'(num_raw[WIDTH-1:0]);
            acc_den_reg <= dm_reg[WIDTH-2:0];
        end
    end

    assign sts.err      = err_c;
    assign sts.ign      = ign_c;
    assign sts.is_load  = (req_reg == REQ_LOAD);
    assign sts.nm_zero  = (nm_reg == 64'd0);
    assign sts.gcd_done = (u_reg == v_reg);
    assign sts.div_done = (cnt_reg == 6'h3f) && div_sel_reg;

    assign result_num = out_num_reg;
    assign result_den = out_den_reg;
    assign status     = out_status_reg;

    `RAU_ASSERT_NOW(a_den_nonzero, 1'b1, acc_den_reg != '0, "accumulator denominator is zero")
    `RAU_ASSERT_NOW(a_gcd_nonzero, cmd.gcd_step, (u_reg != 64'd0) && (v_reg != 64'd0), "gcd operand is zero")
    `RAU_ASSERT_NOW(a_err_not_ign, cmd.finish, !(sts.err && sts.ign), "error raised on ignored code")

endmodule
`default_nettype wire

[src/rational_accumulator_unit_core.sv]
// Top level of the rational accumulator: stream ports, controller and datapath
//
//  channel | dir | beat contents (tdata, lowest bit up)
//  s_*     | in  | req_type[2:0], operand_num[34:3], operand_den[66:35], zero pad
//  m_*     | out | result_num[31:0], result_den[62:32], status[64:63], zero pad
//
// An item passes through accept, dispatch, 3 multiplies on one 32x32 multiplier
// (skipped by loads), combine, the binary GCD (one shift or subtract per cycle),
// the one-bit-per-cycle divider (numerator, then denominator) and finish.
// A zero result skips the GCD steps and the divider.
// Errors and unknown codes go from dispatch straight to finish.
// Reset sets the accumulator to 0/1; no clearing pass.
// A stalled output holds the block in finish until the beat is taken.
`timescale 1ns / 1ps
`default_nettype none
module rational_accumulator_unit_core #(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // req_type, operand_num, operand_den
    input  wire logic [rau_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // result_num, result_den, status
    output logic [rau_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import rau_pkg::*;

    cmd_t        cmd;
    sts_t        sts;
    logic [31:0] result_num;
    logic [30:0] result_den;
    logic [1:0]  status;

    rau_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rau_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_type    (s_tdata[2:0]),
        .operand_num (s_tdata[34:3]),
        .operand_den (s_tdata[66:35]),
        .cmd         (cmd),
        .sts         (sts),
        .result_num  (result_num),
        .result_den  (result_den),
        .status      (status)
    );

    assign m_tdata = {7'd0, status, result_den, result_num};

endmodule
`default_nettype wire

[verif/rau_scoreboard.sv]
// Fraction accumulator predictor and result checker for the stream channels
`timescale 1ns / 1ps
module rau_scoreboard
    import rau_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    fails,
    output int                    pending,
    output int                    results_seen
);

    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        status_t     st;
    } frac_result_t;

    localparam logic [63:0] HALF = 64'd1 << (WIDTH_DEF - 1);
    localparam logic [63:0] TWO32 = 64'h1_0000_0000;

    logic [31:0] acc_num;
    logic [31:0] acc_den;
    frac_result_t expected_q[$];

    function automatic logic [63:0] magnitude(input logic [31:0] v);
        return v[31] ? (TWO32 - {32'd0, v}) : {32'd0, v};
    endfunction

    function automatic logic [64:0] signed_sum(input logic sa, input logic [63:0] ma,
                                               input logic sb, input logic [63:0] mb);
        if (sa == sb)
            return {sa, ma + mb};
        if (ma >= mb)
            return {sa, ma - mb};
        return {sb, mb - ma};
    endfunction

    function automatic logic [63:0] euclid(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        while (b != 0)
        begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    function automatic frac_result_t accumulate(input logic [2:0] rq, input logic [31:0] onr,
                                                input logic [31:0] odr);
        logic [63:0] on, od, an, ad, nm, dm, g, raw;
        logic        os, ns, fits;
        logic [64:0] sum;
        status_t     st;
        frac_result_t r;
        st = ST_OK;
        on = magnitude(onr);
        od = magnitude(odr);
        os = onr[31] ^ odr[31];
        an = magnitude(acc_num);
        ad = {32'd0, acc_den};
        nm = 0;
        dm = 1;
        ns = 0;
        if (rq <= REQ_DIV)
        begin
            if (od == 0 || (rq == REQ_DIV && on == 0))
                st = ST_ZERO;
            else
            begin
                case (req_t'(rq))
                    REQ_LOAD:
                    begin
                        nm = on; dm = od; ns = os;
                    end
                    REQ_ADD:
                    begin
                        sum = signed_sum(acc_num[31], an * od, os, ad * on);
                        ns = sum[64]; nm = sum[63:0]; dm = ad * od;
                    end
                    REQ_SUB:
                    begin
                        sum = signed_sum(acc_num[31], an * od, !os, ad * on);
                        ns = sum[64]; nm = sum[63:0]; dm = ad * od;
                    end
                    REQ_MUL:
                    begin
                        nm = an * on; dm = ad * od; ns = acc_num[31] ^ os;
                    end
                    default:
                    begin
                        nm = an * od; dm = ad * on; ns = acc_num[31] ^ os;
                    end
                endcase
                if (nm == 0)
                begin
                    dm = 1;
                    ns = 0;
                end
                else
                begin
                    g = euclid(nm, dm);
                    nm = nm / g;
                    dm = dm / g;
                end
                fits = (ns ? (nm <= HALF) : (nm < HALF)) && dm < HALF;
                if (!fits)
                    st = ST_OVF;
                else
                begin
                    raw = ns ? (TWO32 - nm) : nm;
                    acc_num = raw[31:0];
                    acc_den = dm[31:0];
                end
            end
        end
        r.num = acc_num;
        r.den = acc_den[30:0];
        r.st = st;
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        frac_result_t e, a;
        if (!rst_n)
        begin
            acc_num = 0;
            acc_den = 1;
            expected_q.delete();
            fails <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                a.num = m_tdata[31:0];
                a.den = m_tdata[62:32];
                a.st = status_t'(m_tdata[64:63]);
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, m_tdata);
                    fails <= fails + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (a.num !== e.num || a.den !== e.den || a.st !== e.st)
                    begin
                        $display("%0t: mismatch expected num=%0d den=%0d st=%0d actual num=%0d den=%0d st=%0d",
                                 $time, $signed(e.num), e.den, e.st,
                                 $signed(a.num), a.den, a.st);
                        fails <= fails + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(accumulate(s_tdata[2:0], s_tdata[34:3], s_tdata[66:35]));
        end
    end

endmodule

[verif/tb_rational_accumulator_unit_core.sv]
// Stimulus and verdict for the rational accumulator stream block
`timescale 1ns / 1ps
module tb_rational_accumulator_unit_core;
    import rau_pkg::*;

    localparam int N_RANDOM = 480;
    localparam int LIMIT = 2000000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    int                    fails, pending, results_seen;
    int                    sent;
    int                    cycles;
    logic                  calm;
    logic                  hold_done;

    rational_accumulator_unit_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    rau_scoreboard chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fails(fails), .pending(pending), .results_seen(results_seen)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9))
            0: return $urandom();
            1: return 32'h8000_0000 | $urandom_range(3);
            2: return 32'h7fff_ffff - $urandom_range(3);
            3, 4: return $urandom_range(65535) - 32768;
            default: return $urandom_range(40) - 20;
        endcase
    endfunction

    task automatic send(input logic [2:0] rq, input logic [31:0] num, input logic [31:0] den);
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, den, num, rq};
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        sent++;
        if (!calm && $urandom_range(3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(10, 1)) @(posedge clk);
        end
    endtask

    task automatic send_random();
        logic [2:0]  rq;
        logic [31:0] den;
        int          k;
        k = $urandom_range(99);
        if (k < 4)
            rq = 3'($urandom_range(7, 5));
        else if (k < 20)
            rq = REQ_LOAD;
        else
            rq = 3'($urandom_range(REQ_DIV, REQ_ADD));
        den = pick_operand();
        if ($urandom_range(15) == 0)
            den = 0;
        send(rq, pick_operand(), den);
    endtask

    initial
    begin
        m_tready <= 1'b0;
        hold_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && sent >= 120)
            begin
                hold_done = 1;
                m_tready <= 1'b0;
                repeat (3000) @(posedge clk);
            end
            else if (!calm && $urandom_range(4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(10, 1)) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        sent = 0;
        calm = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send(REQ_ADD, 32'd3, 32'd4);
        send(REQ_LOAD, 32'd7, 32'hffff_fff2);
        send(REQ_LOAD, 32'h8000_0000, 32'd1);
        send(REQ_LOAD, 32'h8000_0000, 32'hffff_ffff);
        send(REQ_LOAD, 32'h7fff_ffff, 32'd1);
        send(REQ_MUL, 32'd2, 32'd1);
        send(REQ_LOAD, 32'd1, 32'h7fff_ffff);
        send(REQ_DIV, 32'd2, 32'd1);
        send(REQ_LOAD, 32'd2, 32'h8000_0000);
        send(REQ_LOAD, 32'd1, 32'h8000_0000);
        send(REQ_LOAD, 32'd5, 32'd0);
        send(REQ_ADD, 32'd5, 32'd0);
        send(REQ_SUB, 32'd5, 32'd0);
        send(REQ_MUL, 32'd5, 32'd0);
        send(REQ_DIV, 32'd5, 32'd0);
        send(REQ_DIV, 32'd0, 32'd9);
        send(3'd5, 32'd1, 32'd1);
        send(3'd6, 32'hffff_ffff, 32'hffff_ffff);
        send(3'd7, 32'd0, 32'd0);
        send(REQ_ADD, 32'hffff_fffd, 32'd6);
        send(REQ_SUB, 32'd1, 32'd3);
        send(REQ_SUB, 32'hffff_fffe, 32'hffff_fffa);
        send(REQ_MUL, 32'd0, 32'd5);
        send(REQ_DIV, 32'hffff_ffff, 32'd1);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == 240)
            begin
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (pending != 0);
            end
            if (i == N_RANDOM - 60)
                calm = 1;
            send_random();
        end
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (400) @(posedge clk);
        $display("Drove %0d beats (loads, add, sub, mul, div, zero and overflow cases, unknown codes)",
                 sent);
        $display("Checked %0d result beats under random gaps and a long output stall", results_seen);
        if (fails == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/rau_pkg.sv
src/rau_ctrl.sv
src/rau_dp.sv
src/rational_accumulator_unit_core.sv
verif/rau_scoreboard.sv
verif/tb_rational_accumulator_unit_core.sv
